### rtl/hrht_pkg.sv
// ----------------------------------------------------------------------------
// hrht_pkg
// shared types, byte codes, result codes and the method name table for the
// request head tokenizer
// ----------------------------------------------------------------------------
package hrht_pkg;

    // one input beat: a byte of request text
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_beat_t;

    // one result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [3:0] method_code;
        logic [1:0] status;
        logic       last_of_item;
    } out_beat_t;

    // results caused by one input beat, packed from the front
    typedef struct packed {
        out_beat_t  first;
        out_beat_t  second;
        logic [1:0] count;
    } res_pair_t;

    // byte codes
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] SP_BYTE    = 8'h20;
    localparam logic [7:0] COLON_BYTE = 8'h3A;

    // result kinds
    localparam logic [2:0] KIND_PATH      = 3'd0;
    localparam logic [2:0] KIND_NAME      = 3'd1;
    localparam logic [2:0] KIND_VALUE     = 3'd2;
    localparam logic [2:0] KIND_REQ_DONE  = 3'd3;
    localparam logic [2:0] KIND_HDR_DONE  = 3'd4;
    localparam logic [2:0] KIND_HDRS_DONE = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOKENS    = 2'd1;
    localparam logic [1:0] ST_METHOD    = 2'd2;
    localparam logic [1:0] ST_NO_COLON  = 2'd3;

    // parser phases
    localparam logic [1:0] PH_REQ  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_ERR  = 2'd3;

    localparam int NUM_METHODS = 9;
    localparam int METH_CHARS  = 7;

    // method names, left aligned, zero padded
    localparam logic [8*METH_CHARS-1:0] METH_TEXT [NUM_METHODS] = '{
        {"GET",     32'h0},
        {"HEAD",    24'h0},
        {"POST",    24'h0},
        {"PUT",     32'h0},
        {"DELETE",  8'h0},
        "CONNECT",
        "OPTIONS",
        {"TRACE",   16'h0},
        {"PATCH",   16'h0}
    };

    localparam logic [2:0] METH_LEN [NUM_METHODS] = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5
    };

    // methods whose name has byte c at position pos
    function automatic logic [NUM_METHODS-1:0] meth_hit(input logic [2:0] pos,
                                                        input logic [7:0] c);
        logic [NUM_METHODS-1:0] hit;
        hit = '0;
        for (int m = 0; m < NUM_METHODS; m++) begin
            if (pos < METH_LEN[m]) begin
                hit[m] = (METH_TEXT[m][8*METH_CHARS-1-8*pos -: 8] == c);
            end
        end
        return hit;
    endfunction

endpackage

### rtl/hrht_core.sv
// ----------------------------------------------------------------------------
// hrht_core
// tokenizer state and the single-pass result logic for one byte
// ----------------------------------------------------------------------------
module hrht_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  hrht_pkg::in_beat_t beat,
    output hrht_pkg::res_pair_t res
);

    logic [1:0]                       phase_reg, phase_next;
    logic [7:0]                       held_byte_reg, held_byte_next;
    logic                             held_valid_reg, held_valid_next;
    logic [1:0]                       token_index_reg, token_index_next;
    logic [hrht_pkg::NUM_METHODS-1:0] method_match_reg, method_match_next;
    logic [2:0]                       method_position_reg, method_position_next;
    logic                             colon_seen_reg, colon_seen_next;
    logic                             line_released_reg, line_released_next;

    logic                   active;
    logic                   is_lf;
    logic                   rel_emit;
    hrht_pkg::out_beat_t    rel_beat;
    logic                   end_emit;
    hrht_pkg::out_beat_t    end_beat;
    logic                   found;
    logic [3:0]             code;
    logic                   cr_line;

    always_comb
    begin
        phase_next           = phase_reg;
        held_byte_next       = held_byte_reg;
        held_valid_next      = held_valid_reg;
        token_index_next     = token_index_reg;
        method_match_next    = method_match_reg;
        method_position_next = method_position_reg;
        colon_seen_next      = colon_seen_reg;
        line_released_next   = line_released_reg;

        rel_emit = 1'b0;
        rel_beat = '0;
        end_emit = 1'b0;
        end_beat = '0;
        found    = 1'b0;
        code     = 4'd0;
        cr_line  = 1'b0;

        active = (phase_reg == hrht_pkg::PH_REQ) || (phase_reg == hrht_pkg::PH_HDR);
        is_lf  = (beat.data_byte == hrht_pkg::LF_BYTE);

        // release the held byte
        if (active && !is_lf && held_valid_reg)
        begin
            line_released_next = 1'b1;
            if (phase_reg == hrht_pkg::PH_REQ)
            begin
                if (held_byte_reg == hrht_pkg::SP_BYTE)
                begin
                    if (token_index_reg != 2'd3)
                    begin
                        token_index_next = token_index_reg + 2'd1;
                    end
                end
                else if (token_index_reg == 2'd0)
                begin
                    method_match_next = method_match_reg &
                        hrht_pkg::meth_hit(method_position_reg, held_byte_reg);
                    if (method_position_reg != 3'd7)
                    begin
                        method_position_next = method_position_reg + 3'd1;
                    end
                end
                else if (token_index_reg == 2'd1)
                begin
                    rel_emit          = 1'b1;
                    rel_beat.kind     = hrht_pkg::KIND_PATH;
                    rel_beat.out_byte = held_byte_reg;
                end
            end
            else
            begin
                if (!colon_seen_reg && held_byte_reg == hrht_pkg::COLON_BYTE)
                begin
                    colon_seen_next = 1'b1;
                end
                else
                begin
                    rel_emit          = 1'b1;
                    rel_beat.kind     = colon_seen_reg ? hrht_pkg::KIND_VALUE
                                                       : hrht_pkg::KIND_NAME;
                    rel_beat.out_byte = held_byte_reg;
                end
            end
        end

        // take the new byte into the hold
        if (active && !is_lf)
        begin
            held_byte_next  = beat.data_byte;
            held_valid_next = 1'b1;
        end

        // line end, seen by the updated line state
        for (int m = 0; m < hrht_pkg::NUM_METHODS; m++)
        begin
            if (method_match_next[m] && hrht_pkg::METH_LEN[m] == method_position_next)
            begin
                found = 1'b1;
                code  = 4'(m);
            end
        end
        cr_line = held_valid_next && (held_byte_next == hrht_pkg::CR_BYTE) &&
                  !line_released_next;

        if (active && (is_lf || beat.end_of_text))
        begin
            end_emit = 1'b1;
            if (phase_reg == hrht_pkg::PH_REQ)
            begin
                end_beat.kind = hrht_pkg::KIND_REQ_DONE;
                if (token_index_next != 2'd2)
                begin
                    end_beat.status = hrht_pkg::ST_TOKENS;
                    phase_next      = hrht_pkg::PH_ERR;
                end
                else if (!found)
                begin
                    end_beat.status = hrht_pkg::ST_METHOD;
                    phase_next      = hrht_pkg::PH_ERR;
                end
                else
                begin
                    end_beat.method_code = code;
                    phase_next           = hrht_pkg::PH_HDR;
                end
            end
            else if (cr_line)
            begin
                end_beat.kind = hrht_pkg::KIND_HDRS_DONE;
                phase_next    = hrht_pkg::PH_DONE;
            end
            else
            begin
                end_beat.kind   = hrht_pkg::KIND_HDR_DONE;
                end_beat.status = colon_seen_next ? hrht_pkg::ST_OK
                                                  : hrht_pkg::ST_NO_COLON;
            end
        end

        // clear the line, and the whole request at end of text
        if (end_emit || beat.end_of_text)
        begin
            held_byte_next       = 8'd0;
            held_valid_next      = 1'b0;
            token_index_next     = 2'd0;
            method_match_next    = '1;
            method_position_next = 3'd0;
            colon_seen_next      = 1'b0;
            line_released_next   = 1'b0;
        end
        if (beat.end_of_text)
        begin
            phase_next = hrht_pkg::PH_REQ;
        end

        // pack results from the front, mark the last one
        res = '0;
        if (rel_emit)
        begin
            res.first              = rel_beat;
            res.first.last_of_item = !end_emit;
            res.second             = end_beat;
            res.second.last_of_item = 1'b1;
            res.count              = end_emit ? 2'd2 : 2'd1;
        end
        else if (end_emit)
        begin
            res.first              = end_beat;
            res.first.last_of_item = 1'b1;
            res.count              = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= hrht_pkg::PH_REQ;
            held_byte_reg       <= 8'd0;
            held_valid_reg      <= 1'b0;
            token_index_reg     <= 2'd0;
            method_match_reg    <= '1;
            method_position_reg <= 3'd0;
            colon_seen_reg      <= 1'b0;
            line_released_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            held_byte_reg       <= held_byte_next;
            held_valid_reg      <= held_valid_next;
            token_index_reg     <= token_index_next;
            method_match_reg    <= method_match_next;
            method_position_reg <= method_position_next;
            colon_seen_reg      <= colon_seen_next;
            line_released_reg   <= line_released_next;
        end
    end

endmodule

### rtl/hrht_res_fifo.sv
// ----------------------------------------------------------------------------
// hrht_res_fifo
// four-entry result queue, up to two beats in a cycle, one out unless stalled
// ----------------------------------------------------------------------------
module hrht_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hrht_pkg::res_pair_t pair,
    output logic                room,
    output logic                valid,
    input  logic                stall,
    output hrht_pkg::out_beat_t beat
);

    hrht_pkg::out_beat_t mem_reg [4];
    logic [1:0]          wr_ptr_reg, wr_ptr_next;
    logic [1:0]          rd_ptr_reg, rd_ptr_next;
    logic [2:0]          count_reg, count_next;
    logic [1:0]          n_in;
    logic                pop;

    assign n_in  = push ? pair.count : 2'd0;
    assign valid = (count_reg != 3'd0);
    assign pop   = valid && !stall;
    assign room  = (count_reg <= 3'd2);
    assign beat  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_in;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_in} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= pair.first;
        end
        if (n_in == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= pair.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/http_request_head_tokenizer_top.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_top
// byte-wide tokenizer for the head of an http/1.1 request
// ----------------------------------------------------------------------------
// takes the request text one byte per beat and gives path, header name and
// header value bytes plus line events (request line done with method code,
// header done, headers done). one byte is always held back so the last byte
// of each line, normally cr, can be dropped. a beat with end_of_text set
// closes the current line and returns the tokenizer to its start state for
// the next request. throughput is one input beat per cycle as long as each
// byte gives at most one result and res_stall stays low; the result port
// gives one beat per cycle when not stalled, so a byte that gives two
// results (a released byte plus a line event on the final byte) sends them
// one after the other. an input beat passes the input register, then the
// line logic into the four-entry result queue. the input side stalls only
// while the queue cannot take the two results a byte may cause.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer_top (
    input  logic                clk,
    input  logic                rst_n,
    // request text beats
    input  logic                req_valid,
    output logic                req_stall,
    input  hrht_pkg::in_beat_t  req_beat,
    // result beats
    output logic                res_valid,
    input  logic                res_stall,
    output hrht_pkg::out_beat_t res_beat
);

    // input register
    logic               in_valid_reg, in_valid_next;
    hrht_pkg::in_beat_t in_beat_reg;

    logic                accept;
    logic                consume;
    logic                room;
    hrht_pkg::res_pair_t pair;

    // the held item moves on when the queue has space for two results
    assign consume   = in_valid_reg && room;
    assign req_stall = in_valid_reg && !room;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        in_valid_next = accept || (in_valid_reg && !consume);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg <= req_beat;
        end
    end

    // line state and per-byte result logic
    hrht_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (consume),
        .beat  (in_beat_reg),
        .res   (pair)
    );

    // result queue, doubles as the output register
    hrht_res_fifo u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (consume),
        .pair  (pair),
        .room  (room),
        .valid (res_valid),
        .stall (res_stall),
        .beat  (res_beat)
    );

endmodule

### sim/tb_http_request_head_tokenizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_head_tokenizer_top
// self-checking bench for the http request head tokenizer
// ----------------------------------------------------------------------------
// text beats come from a queue filled at time zero: a short directed set of
// requests for the corner cases, then random requests that are mostly well
// formed with some noise and broken lines mixed in. every accepted beat runs
// through a behavioural tokenizer that queues the result beats it should
// cause. every result beat is checked field by field against the oldest
// queued one. the sender idles in bursts and gaps, the receiver stalls on a
// changing pattern and once holds off for a long stretch so the block backs
// up onto its input.
// ----------------------------------------------------------------------------
module tb_http_request_head_tokenizer_top;

    // method codes as carried on method_code
    typedef enum logic [3:0] {
        M_GET, M_HEAD, M_POST, M_PUT, M_DELETE, M_CONNECT, M_OPTIONS, M_TRACE, M_PATCH
    } method_e;

    // receiver stall patterns
    typedef enum logic [1:0] {
        FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_EVERY_THIRD
    } flow_e;

    localparam int RANDOM_BEATS    = 1050;
    localparam int HOLD_AFTER      = 300;     // text beats in before the long hold-off
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 8;       // pause at the end
    localparam int CYCLE_LIMIT     = 300000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    hrht_pkg::in_beat_t  req_beat = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    hrht_pkg::out_beat_t res_beat;

    http_request_head_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // queues and counters
    // ------------------------------------------------------------------------
    hrht_pkg::in_beat_t  pending_text[$];       // text beats still to be offered
    hrht_pkg::out_beat_t expected_tokens[$];    // result beats still to arrive, oldest first
    hrht_pkg::out_beat_t step_tokens[$];        // results of the byte being tokenized
    logic [7:0]          request_bytes[$];      // request under construction

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  beats_in = 0;
    int  requests_in = 0;
    int  results_seen = 0;
    int  content_bytes = 0;
    int  line_events = 0;
    int  input_held_cycles = 0;
    logic beat_taken = 1'b0;

    // ------------------------------------------------------------------------
    // behavioural tokenizer state
    // ------------------------------------------------------------------------
    logic [7:0] held_char;
    logic       held_ok;
    logic [1:0] tok_phase;
    logic [1:0] space_count;          // spaces in the request line, saturating at 3
    logic [hrht_pkg::NUM_METHODS-1:0] method_alive;   // one bit per method still possible
    logic [2:0] first_len;            // bytes of the first token, saturating at 7
    logic       colon_found;
    logic       line_started;         // a byte of this line has left the hold

    function automatic string meth_word(input method_e m);
        case (m)
            M_GET:     return "GET";
            M_HEAD:    return "HEAD";
            M_POST:    return "POST";
            M_PUT:     return "PUT";
            M_DELETE:  return "DELETE";
            M_CONNECT: return "CONNECT";
            M_OPTIONS: return "OPTIONS";
            M_TRACE:   return "TRACE";
            default:   return "PATCH";
        endcase
    endfunction

    function automatic void add_token(input logic [2:0] kind, input logic [7:0] b,
                                      input logic [3:0] code, input logic [1:0] st);
        hrht_pkg::out_beat_t r;
        r.kind = kind;
        r.out_byte = b;
        r.method_code = code;
        r.status = st;
        r.last_of_item = 1'b0;
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    task automatic clear_line();
        held_char = '0;
        held_ok = 1'b0;
        line_started = 1'b0;
        colon_found = 1'b0;
        space_count = '0;
        method_alive = '1;
        first_len = '0;
    endtask

    task automatic restart_request();
        tok_phase = hrht_pkg::PH_REQ;
        clear_line();
    endtask

    // line feed or end of text: give the line event
    task automatic close_line();
        logic    found;
        method_e code;
        string   name;
        found = 1'b0;
        code = M_GET;
        if (tok_phase == hrht_pkg::PH_REQ)
        begin
            for (int m = 0; m < hrht_pkg::NUM_METHODS; m++)
            begin
                name = meth_word(method_e'(m));
                if (method_alive[m] && name.len() == first_len)
                begin
                    found = 1'b1;
                    code = method_e'(m);
                end
            end
            // token count is checked first and wins over an unknown method
            if (space_count != 2'd2)
            begin
                add_token(hrht_pkg::KIND_REQ_DONE, 8'h00, 4'd0, hrht_pkg::ST_TOKENS);
                tok_phase = hrht_pkg::PH_ERR;
            end
            else if (!found)
            begin
                add_token(hrht_pkg::KIND_REQ_DONE, 8'h00, 4'd0, hrht_pkg::ST_METHOD);
                tok_phase = hrht_pkg::PH_ERR;
            end
            else
            begin
                add_token(hrht_pkg::KIND_REQ_DONE, 8'h00, code, hrht_pkg::ST_OK);
                tok_phase = hrht_pkg::PH_HDR;
            end
        end
        else if (tok_phase == hrht_pkg::PH_HDR)
        begin
            // a line that is a lone cr ends the header block
            if (held_ok && held_char == hrht_pkg::CR_BYTE && !line_started)
            begin
                add_token(hrht_pkg::KIND_HDRS_DONE, 8'h00, 4'd0, hrht_pkg::ST_OK);
                tok_phase = hrht_pkg::PH_DONE;
            end
            else
            begin
                add_token(hrht_pkg::KIND_HDR_DONE, 8'h00, 4'd0,
                          colon_found ? hrht_pkg::ST_OK : hrht_pkg::ST_NO_COLON);
            end
        end
        clear_line();
    endtask

    // one accepted text beat in, its expected results onto expected_tokens
    task automatic tokenize_byte(input hrht_pkg::in_beat_t beat);
        logic [7:0]          c;
        string               name;
        hrht_pkg::out_beat_t r;
        step_tokens.delete();
        if (tok_phase == hrht_pkg::PH_REQ || tok_phase == hrht_pkg::PH_HDR)
        begin
            if (beat.data_byte == hrht_pkg::LF_BYTE)
            begin
                close_line();
            end
            else
            begin
                // the byte held so far is no longer the last of its line
                if (held_ok)
                begin
                    c = held_char;
                    line_started = 1'b1;
                    if (tok_phase == hrht_pkg::PH_REQ)
                    begin
                        if (c == hrht_pkg::SP_BYTE)
                        begin
                            if (space_count != 2'd3) space_count++;
                        end
                        else if (space_count == 2'd0)
                        begin
                            for (int m = 0; m < hrht_pkg::NUM_METHODS; m++)
                            begin
                                name = meth_word(method_e'(m));
                                if (first_len >= name.len() || name[first_len] != c)
                                    method_alive[m] = 1'b0;
                            end
                            if (first_len != 3'd7) first_len++;
                        end
                        else if (space_count == 2'd1)
                        begin
                            add_token(hrht_pkg::KIND_PATH, c, 4'd0, hrht_pkg::ST_OK);
                        end
                    end
                    else
                    begin
                        if (!colon_found && c == hrht_pkg::COLON_BYTE)
                            colon_found = 1'b1;
                        else
                            add_token(colon_found ? hrht_pkg::KIND_VALUE
                                                  : hrht_pkg::KIND_NAME,
                                      c, 4'd0, hrht_pkg::ST_OK);
                    end
                end
                held_char = beat.data_byte;
                held_ok = 1'b1;
                // a final byte that is not a line feed closes the line itself
                if (beat.end_of_text) close_line();
            end
        end
        if (beat.end_of_text) restart_request();
        if (step_tokens.size() != 0)
        begin
            r = step_tokens.pop_back();
            r.last_of_item = 1'b1;
            step_tokens.insert(step_tokens.size(), r);
        end
        while (step_tokens.size() != 0)
            expected_tokens.insert(expected_tokens.size(), step_tokens.pop_front());
    endtask

    // ------------------------------------------------------------------------
    // request text construction
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        request_bytes.insert(request_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // cr lf, now and then a bare lf
    task automatic add_line_end();
        if ($urandom_range(0, 15) != 0) add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
    endtask

    // any byte but a line feed and one other
    function automatic logic [7:0] text_byte(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == hrht_pkg::LF_BYTE || b == avoid);
        return b;
    endfunction

    // move the request onto the beat queue, end_of_text on its last byte
    task automatic flush_request();
        hrht_pkg::in_beat_t beat;
        if (request_bytes.size() == 0) add_byte(hrht_pkg::CR_BYTE);
        while (request_bytes.size() != 0)
        begin
            beat.data_byte = request_bytes.pop_front();
            beat.end_of_text = (request_bytes.size() == 0);
            pending_text.insert(pending_text.size(), beat);
        end
    endtask

    task automatic queue_random_request();
        int flaw;
        int n;
        int k;
        int cut;
        // pure noise now and then, line feeds included
        if ($urandom_range(0, 19) == 0)
        begin
            n = $urandom_range(1, 24);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
            flush_request();
            return;
        end
        flaw = $urandom_range(0, 11);     // above 7 the request gets broken somehow
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(0, 9);
            repeat (n) add_byte(8'($urandom_range(8'h41, 8'h5A)));
        end
        else
        begin
            add_text(meth_word(method_e'($urandom_range(0, hrht_pkg::NUM_METHODS - 1))));
        end
        if (flaw != 8) add_byte(hrht_pkg::SP_BYTE);
        n = $urandom_range(0, 8);
        repeat (n) add_byte(text_byte(hrht_pkg::SP_BYTE));
        add_byte(hrht_pkg::SP_BYTE);
        n = $urandom_range(1, 4);
        repeat (n) add_byte(text_byte(hrht_pkg::SP_BYTE));
        if (flaw == 9) add_text(" x");
        add_line_end();
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            k = $urandom_range(1, 5);
            repeat (k) add_byte(text_byte(hrht_pkg::COLON_BYTE));
            if ($urandom_range(0, 9) != 0) add_byte(hrht_pkg::COLON_BYTE);
            k = $urandom_range(0, 6);
            repeat (k) add_byte(text_byte(hrht_pkg::LF_BYTE));
            add_line_end();
        end
        if (flaw != 10) add_line_end();
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(1, 4);
            repeat (k) add_byte(text_byte(hrht_pkg::LF_BYTE));
        end
        // cut short at a random point
        if (flaw == 11 && request_bytes.size() > 1)
        begin
            cut = $urandom_range(1, request_bytes.size() - 1);
            while (request_bytes.size() > cut) void'(request_bytes.pop_back());
        end
        flush_request();
    endtask

    // ------------------------------------------------------------------------
    // stimulus, reset and the end of the run
    // ------------------------------------------------------------------------
    initial
    begin
        restart_request();

        // full request: extreme bytes in path and value, a second colon in a value,
        // blank line closing the headers, last byte a line feed
        add_text("GET ");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text(" H");
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_text("Host:");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_text("a:b");
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        flush_request();

        // one token only: wrong count and unknown method at once, then ignored bytes
        add_text("BAD");
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_text("abc");
        flush_request();

        // empty request line
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        flush_request();

        // unknown method, empty first token, first token too long
        add_text("FOO / v");
        add_byte(hrht_pkg::LF_BYTE);
        flush_request();
        add_text(" / v");
        add_byte(hrht_pkg::LF_BYTE);
        flush_request();
        add_text("CONNECTX / v");
        add_byte(hrht_pkg::LF_BYTE);
        flush_request();

        // too many tokens
        add_text("PUT / v w");
        add_byte(hrht_pkg::LF_BYTE);
        flush_request();

        // colon as last byte of a line, empty header line, final byte not a line
        // feed and no blank line before the end
        add_text("OPTIONS / v");
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_text("X:");
        add_byte(hrht_pkg::LF_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_text("n");
        flush_request();

        // bytes after the header block are dropped
        add_text("HEAD / v");
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_byte(hrht_pkg::CR_BYTE);
        add_byte(hrht_pkg::LF_BYTE);
        add_text("xyz");
        flush_request();

        // lone byte carrying end_of_text
        add_byte(8'hFF);
        flush_request();

        while (pending_text.size() < RANDOM_BEATS) queue_random_request();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every beat offered and taken, then every result in
        while (pending_text.size() != 0 || req_valid) @(posedge clk);
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d requests in %0d text beats, %0d result beats checked",
                 requests_in, beats_in, results_seen);
        $display("run: %0d content bytes, %0d line events, input stalled on %0d cycles",
                 content_bytes, line_events, input_held_cycles);
        if (mismatch_count == 0)
            $display("http_request_head_tokenizer_top verification clean");
        else
            $display("http_request_head_tokenizer_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender: bursts of beats with gaps between, driven on the falling edge
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge clk)
    begin : drive_text
        hrht_pkg::in_beat_t next_beat;
        logic               next_valid;
        if (rst_n && (!req_valid || beat_taken))
        begin
            next_valid = 1'b0;
            next_beat = req_beat;
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (pending_text.size() != 0)
            begin
                next_beat = pending_text.pop_front();
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // back to back or a short gap, rarely a long one
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        9:          gap_left = $urandom_range(10, 30);
                        default:    gap_left = $urandom_range(1, 5);
                    endcase
                end
            end
            req_valid <= next_valid;
            req_beat <= next_beat;
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: a changing pattern, plus one long hold-off once enough
    // text has gone in
    // ------------------------------------------------------------------------
    flow_e flow_mode = FLOW_FREE;
    int    flow_left = 0;
    int    hold_left = 0;
    logic  hold_done = 1'b0;

    always @(negedge clk)
    begin : drive_result_stall
        logic stall_next;
        if (rst_n)
        begin
            if (!hold_done && beats_in >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (flow_left == 0)
            begin
                flow_mode = flow_e'($urandom_range(0, 3));
                flow_left = $urandom_range(16, 96);
            end
            else
            begin
                flow_left--;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else
            begin
                case (flow_mode)
                    FLOW_LIGHT:       stall_next = ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY:       stall_next = ($urandom_range(0, 9) < 7);
                    FLOW_EVERY_THIRD: stall_next = (cycle_count % 3 == 0);
                    default:          stall_next = 1'b0;
                endcase
            end
            res_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes seen at the rising edge
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : watch_beats
        hrht_pkg::out_beat_t want;
        beat_taken <= req_valid && !req_stall;
        if (rst_n)
        begin
            if (req_valid && req_stall) input_held_cycles <= input_held_cycles + 1;
            if (req_valid && !req_stall)
            begin
                tokenize_byte(req_beat);
                beats_in <= beats_in + 1;
                if (req_beat.end_of_text) requests_in <= requests_in + 1;
            end
            if (res_valid && !res_stall)
            begin
                results_seen <= results_seen + 1;
                if (res_beat.kind <= hrht_pkg::KIND_VALUE)
                    content_bytes <= content_bytes + 1;
                else
                    line_events <= line_events + 1;
                if (expected_tokens.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %0d with nothing expected (kind %0d)",
                                              results_seen, res_beat.kind));
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (res_beat.kind !== want.kind)
                        report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                                  results_seen, res_beat.kind, want.kind));
                    if (res_beat.out_byte !== want.out_byte)
                        report_mismatch($sformatf("result %0d byte %02h, expected %02h",
                                                  results_seen, res_beat.out_byte,
                                                  want.out_byte));
                    if (res_beat.method_code !== want.method_code)
                        report_mismatch($sformatf("result %0d method %0d, expected %0d",
                                                  results_seen, res_beat.method_code,
                                                  want.method_code));
                    if (res_beat.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  results_seen, res_beat.status, want.status));
                    if (res_beat.last_of_item !== want.last_of_item)
                        report_mismatch($sformatf("result %0d last flag %0b, expected %0b",
                                                  results_seen, res_beat.last_of_item,
                                                  want.last_of_item));
                end
            end
        end
    end

    // hang guard
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d beats unsent and %0d results outstanding",
                     pending_text.size(), expected_tokens.size());
            $display("http_request_head_tokenizer_top verification failed");
            $finish;
        end
    end

endmodule
